// ----- rtl/core/ddo_pkg.sv -----
// Shared types, constants and functions of the differential drive odometry unit.
`default_nettype none
package ddo_pkg;

  // Divider geometry: 50-bit dividend, 20-bit divisor, two quotient bits a cycle
  localparam int DIV_W     = 50;
  localparam int REM_W     = 20;
  localparam int DIV_ITERS = 25;

  // Heading constants, 16 fraction bits
  localparam logic [18:0] TWOPI     = 19'd411775;
  localparam logic [19:0] TWO_TWOPI = 20'd823550;
  localparam logic [18:0] PI_F      = 19'd205887;
  localparam logic [18:0] HALF_PI   = 19'd102944;

  // CORDIC: 30 fraction bits, 16 rotations, starts from the gain constant
  localparam int CORDIC_STEPS = 16;
  localparam logic signed [32:0] CORDIC_GAIN = 33'sd652032874;

  typedef enum logic [3:0] {
    S_IDLE,
    S_PREP,
    S_DIV_Q,
    S_DIV_R,
    S_MID,
    S_FOLD,
    S_ROT,
    S_MUL_X,
    S_MUL_Y,
    S_UPD
  } ddo_state_t;

  typedef struct packed {
    logic             start;
    logic [DIV_W-1:0] dividend;
    logic [REM_W-1:0] divisor;
  } ddo_div_req_t;

  typedef struct packed {
    logic             done;
    logic [DIV_W-1:0] quotient;
    logic [REM_W-1:0] remainder;
  } ddo_div_rsp_t;

  // atan(2^-i), 30 fraction bits
  function automatic logic signed [32:0] atan_q30(input logic [3:0] i);
    logic signed [32:0] v;
    case (i)
      4'd0:    v = 33'sd843314857;
      4'd1:    v = 33'sd497837829;
      4'd2:    v = 33'sd263043837;
      4'd3:    v = 33'sd133525159;
      4'd4:    v = 33'sd67021687;
      4'd5:    v = 33'sd33543516;
      4'd6:    v = 33'sd16775851;
      4'd7:    v = 33'sd8388437;
      4'd8:    v = 33'sd4194283;
      4'd9:    v = 33'sd2097149;
      4'd10:   v = 33'sd1048576;
      4'd11:   v = 33'sd524288;
      4'd12:   v = 33'sd262144;
      4'd13:   v = 33'sd131072;
      4'd14:   v = 33'sd65536;
      default: v = 33'sd32768;
    endcase
    return v;
  endfunction

  // Add or subtract an offset below TWOPI from an angle, wrapping into [0, TWOPI)
  function automatic logic [18:0] wrap_step(input logic [18:0] ang, input logic [18:0] off,
                                            input logic sub);
    logic [19:0] t;
    logic [19:0] res;
    if (sub) begin
      t   = {1'b0, ang} - {1'b0, off};
      res = (ang < off) ? t + {1'b0, TWOPI} : t;
    end else begin
      t   = {1'b0, ang} + {1'b0, off};
      res = (t >= {1'b0, TWOPI}) ? t - {1'b0, TWOPI} : t;
    end
    return res[18:0];
  endfunction

endpackage
`default_nettype wire

// ----- rtl/core/differential_drive_odometry_unit.sv -----
// Top level of the differential drive dead-reckoning odometry unit.
//
// channel | direction | beat contents
// in      | slave     | tdata: left_count[31:0], right_count[63:32]
// out     | master    | tdata: x_position[47:0], y_position[95:48], heading[114:96]
// cfg     | write     | axle_ticks[9:0], written when cfg_wr_en is high
//
// One sample passes from acceptance to result through two passes of the
// shared two-bit-per-cycle divider (25 iterations each; heading change, then its reduction
// modulo 4pi), 16 CORDIC rotations on one shift-add unit, two passes of one multiplier,
// and the control states prep, midpoint, fold and update; update waits for a free output.
// Reset clears position, heading and the previous counts; axle_ticks returns to 33.
// in_tready is high only while idle; a finished result waits in the output register,
// and the next sample is accepted meanwhile, up to the point of updating position.
`default_nettype none
module differential_drive_odometry_unit (
  input  wire         clk,
  input  wire         rst_n,
  input  wire         in_tvalid,
  output logic        in_tready,
  input  wire  [63:0] in_tdata,     // left_count[31:0], right_count[63:32]
  output logic        out_tvalid,
  input  wire         out_tready,
  output logic [119:0] out_tdata,   // x_position[47:0], y_position[95:48], heading[114:96]
  input  wire         cfg_wr_en,
  input  wire  [9:0]  cfg_wr_data   // axle_ticks
);

  ddo_pkg::ddo_state_t state_r, state_nxt;
  ddo_pkg::ddo_div_req_t div_req;
  ddo_pkg::ddo_div_rsp_t div_rsp;

  logic [9:0]          axle_r;
  logic [31:0]         prev_l_r, prev_r_r;
  logic signed [31:0]  dl_r, dr_r;
  logic signed [32:0]  sum_r;
  logic                neg_r;
  logic [19:0]         s_r;
  logic [18:0]         mid_r, ang_new_r;
  logic signed [32:0]  x_r, y_r, z_r;
  logic                flip_r;
  logic [3:0]          iter_r;
  logic signed [65:0]  prod_r;
  logic signed [50:0]  dx_r;
  logic signed [47:0]  pos_x_r, pos_y_r;
  logic [18:0]         angle_r;
  logic                out_tvalid_r;

  logic in_acc, out_acc, upd_go;
  assign in_acc  = in_tvalid && in_tready;
  assign out_acc = out_tvalid_r && out_tready;
  assign upd_go  = (state_r == ddo_pkg::S_UPD) && (!out_tvalid_r || out_tready);

  // Prep arithmetic: difference magnitude and rounding offset
  logic signed [32:0] diff;
  logic [32:0]        diff_mag;
  logic [9:0]         axle_eff;
  logic [48:0]        num_rnd;
  always_comb begin
    diff     = {dr_r[31], dr_r} - {dl_r[31], dl_r};
    diff_mag = diff[32] ? 33'(-diff) : diff;
    axle_eff = (axle_r == 10'd0) ? 10'd1 : axle_r;
    num_rnd  = {diff_mag[32:0], 16'd0} + {40'd0, axle_eff[9:1]};
  end

  // Divider requests
  always_comb begin
    div_req = '0;
    if (state_r == ddo_pkg::S_PREP) begin
      div_req.start    = 1'b1;
      div_req.dividend = {1'b0, num_rnd};
      div_req.divisor  = {10'd0, axle_eff};
    end else if (state_r == ddo_pkg::S_DIV_Q && div_rsp.done) begin
      div_req.start    = 1'b1;
      div_req.dividend = {1'b0, div_rsp.quotient[48:0]};
      div_req.divisor  = ddo_pkg::TWO_TWOPI;
    end
  end

  ddo_divider u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  // Heading offsets from the remainder modulo 4pi
  logic [19:0] s_red;
  logic [18:0] half_off, full_off;
  always_comb begin
    s_red    = (s_r >= {1'b0, ddo_pkg::TWOPI}) ? s_r - {1'b0, ddo_pkg::TWOPI} : s_r;
    half_off = s_r[19:1];
    full_off = s_red[18:0];
  end

  // Quadrant fold of the midpoint heading
  logic signed [20:0] mm0, mm1;
  logic               flip_c;
  logic signed [34:0] z_wide;
  always_comb begin
    mm0    = (mid_r > ddo_pkg::PI_F) ? $signed({2'b0, mid_r}) - $signed({2'b0, ddo_pkg::TWOPI})
                                     : $signed({2'b0, mid_r});
    flip_c = 1'b0;
    mm1    = mm0;
    if (mm0 > $signed({2'b0, ddo_pkg::HALF_PI})) begin
      mm1    = mm0 - $signed({2'b0, ddo_pkg::PI_F});
      flip_c = 1'b1;
    end else if (mm0 < -$signed({2'b0, ddo_pkg::HALF_PI})) begin
      mm1    = mm0 + $signed({2'b0, ddo_pkg::PI_F});
      flip_c = 1'b1;
    end
    z_wide = {mm1, 14'd0};
  end

  // CORDIC rotation step
  logic signed [32:0] xs, ys, atan_v;
  always_comb begin
    xs     = x_r >>> iter_r;
    ys     = y_r >>> iter_r;
    atan_v = ddo_pkg::atan_q30(iter_r);
  end

  // Shared multiplier operand and rounded shift of its product
  logic signed [32:0] mul_b;
  logic signed [65:0] prod_c, prod_rnd;
  logic signed [50:0] d_rnd;
  always_comb begin
    mul_b    = (state_r == ddo_pkg::S_MUL_X) ? (flip_r ? -x_r : x_r) : (flip_r ? -y_r : y_r);
    prod_c   = sum_r * mul_b;
    prod_rnd = prod_r + 66'sd16384;
    d_rnd    = prod_rnd[65:15];
  end

  // Saturating position update
  function automatic logic signed [47:0] sat_add(input logic signed [47:0] p,
                                                 input logic signed [50:0] d);
    logic signed [51:0] t;
    logic signed [47:0] res;
    t = {{4{p[47]}}, p} + {d[50], d};
    if (t > 52'sh7FFFFFFFFFFF)       res = 48'sh7FFFFFFFFFFF;
    else if (t < -52'sh800000000000) res = 48'sh800000000000;
    else                             res = t[47:0];
    return res;
  endfunction

  // State register
  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= ddo_pkg::S_IDLE;
    else        state_r <= state_nxt;
  end

  // Next state and handshake
  always_comb begin
    state_nxt = state_r;
    in_tready = 1'b0;
    case (state_r)
      ddo_pkg::S_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) state_nxt = ddo_pkg::S_PREP;
      end
      ddo_pkg::S_PREP:  state_nxt = ddo_pkg::S_DIV_Q;
      ddo_pkg::S_DIV_Q: if (div_rsp.done) state_nxt = ddo_pkg::S_DIV_R;
      ddo_pkg::S_DIV_R: if (div_rsp.done) state_nxt = ddo_pkg::S_MID;
      ddo_pkg::S_MID:   state_nxt = ddo_pkg::S_FOLD;
      ddo_pkg::S_FOLD:  state_nxt = ddo_pkg::S_ROT;
      ddo_pkg::S_ROT:   if (iter_r == 4'(ddo_pkg::CORDIC_STEPS - 1)) state_nxt = ddo_pkg::S_MUL_X;
      ddo_pkg::S_MUL_X: state_nxt = ddo_pkg::S_MUL_Y;
      ddo_pkg::S_MUL_Y: state_nxt = ddo_pkg::S_UPD;
      ddo_pkg::S_UPD:   if (upd_go) state_nxt = ddo_pkg::S_IDLE;
      default:          state_nxt = ddo_pkg::S_IDLE;
    endcase
  end

  // Control state: config, odometry state, output valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      axle_r       <= 10'd33;
      prev_l_r     <= '0;
      prev_r_r     <= '0;
      pos_x_r      <= '0;
      pos_y_r      <= '0;
      angle_r      <= '0;
      out_tvalid_r <= 1'b0;
      iter_r       <= '0;
    end else begin
      if (cfg_wr_en) axle_r <= cfg_wr_data;
      if (in_acc) begin
        prev_l_r <= in_tdata[31:0];
        prev_r_r <= in_tdata[63:32];
      end
      if (state_r == ddo_pkg::S_FOLD) iter_r <= '0;
      else if (state_r == ddo_pkg::S_ROT) iter_r <= iter_r + 4'd1;
      if (upd_go) begin
        pos_x_r      <= sat_add(pos_x_r, dx_r);
        pos_y_r      <= sat_add(pos_y_r, d_rnd);
        angle_r      <= ang_new_r;
        out_tvalid_r <= 1'b1;
      end else if (out_acc) begin
        out_tvalid_r <= 1'b0;
      end
    end
  end

  // Payload datapath
  always_ff @(posedge clk) begin
    if (in_acc) begin
      dl_r <= $signed(in_tdata[31:0] - prev_l_r);
      dr_r <= $signed(in_tdata[63:32] - prev_r_r);
    end
    if (state_r == ddo_pkg::S_PREP) begin
      sum_r <= {dr_r[31], dr_r} + {dl_r[31], dl_r};
      neg_r <= diff[32];
    end
    if (state_r == ddo_pkg::S_DIV_R && div_rsp.done) s_r <= div_rsp.remainder;
    if (state_r == ddo_pkg::S_MID) begin
      mid_r     <= ddo_pkg::wrap_step(angle_r, half_off, neg_r);
      ang_new_r <= ddo_pkg::wrap_step(angle_r, full_off, neg_r);
    end
    if (state_r == ddo_pkg::S_FOLD) begin
      z_r    <= z_wide[32:0];
      x_r    <= ddo_pkg::CORDIC_GAIN;
      y_r    <= '0;
      flip_r <= flip_c;
    end
    if (state_r == ddo_pkg::S_ROT) begin
      if (!z_r[32]) begin
        x_r <= x_r - ys;
        y_r <= y_r + xs;
        z_r <= z_r - atan_v;
      end else begin
        x_r <= x_r + ys;
        y_r <= y_r - xs;
        z_r <= z_r + atan_v;
      end
    end
    if (state_r == ddo_pkg::S_MUL_X) prod_r <= prod_c;
    if (state_r == ddo_pkg::S_MUL_Y) begin
      dx_r   <= d_rnd;
      prod_r <= prod_c;
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = {5'd0, angle_r, pos_y_r, pos_x_r};

`ifndef SYNTH
  a_heading_range: assert property (@(posedge clk) disable iff (!rst_n)
    angle_r < ddo_pkg::TWOPI) else $error("heading out of range");
  a_div_done_state: assert property (@(posedge clk) disable iff (!rst_n)
    div_rsp.done |-> (state_r == ddo_pkg::S_DIV_Q || state_r == ddo_pkg::S_DIV_R))
    else $error("divider finished outside a divide state");
  a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> state_r == ddo_pkg::S_PREP) else $error("accepted beat not started");
  a_upd_needs_slot: assert property (@(posedge clk) disable iff (!rst_n)
    upd_go |-> (!out_tvalid_r || out_tready)) else $error("result overwritten");
`endif

endmodule
`default_nettype wire

// ----- rtl/core/ddo_divider.sv -----
// Shared restoring divider, two quotient bits per cycle.
`default_nettype none
module ddo_divider (
  input  wire                 clk,
  input  wire                 rst_n,
  input  wire ddo_pkg::ddo_div_req_t req,
  output ddo_pkg::ddo_div_rsp_t rsp
);

  logic [ddo_pkg::DIV_W-1:0] dq_r, dq_nxt;
  logic [ddo_pkg::REM_W-1:0] rem_r, rem_nxt, dvs_r;
  logic [4:0]                cnt_r;
  logic                      busy_r, done_r;

  logic [ddo_pkg::REM_W:0] r0, r1, m0, m1;
  logic                    ge0, ge1;

  // Two restoring steps on the partial remainder
  always_comb begin
    r0      = {rem_r, dq_r[ddo_pkg::DIV_W-1]};
    ge0     = r0 >= {1'b0, dvs_r};
    m0      = ge0 ? r0 - {1'b0, dvs_r} : r0;
    r1      = {m0[ddo_pkg::REM_W-1:0], dq_r[ddo_pkg::DIV_W-2]};
    ge1     = r1 >= {1'b0, dvs_r};
    m1      = ge1 ? r1 - {1'b0, dvs_r} : r1;
    rem_nxt = m1[ddo_pkg::REM_W-1:0];
    dq_nxt  = {dq_r[ddo_pkg::DIV_W-3:0], ge0, ge1};
  end

  // Control: load on start, iterate while busy, pulse done
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 5'd1;
        if (cnt_r == 5'(ddo_pkg::DIV_ITERS - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // Datapath
  always_ff @(posedge clk) begin
    if (req.start) begin
      dq_r  <= req.dividend;
      rem_r <= '0;
      dvs_r <= req.divisor;
    end else if (busy_r) begin
      dq_r  <= dq_nxt;
      rem_r <= rem_nxt;
    end
  end

  assign rsp.done      = done_r;
  assign rsp.quotient  = dq_r;
  assign rsp.remainder = rem_r;

endmodule
`default_nettype wire
